// ===== hdl/kss_pkg.sv =====
// ============================================================================
// kss_pkg
// shared types, sizes and helpers of the k-sorted stream sorter
// ============================================================================
package kss_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int WIN_W      = 5;
	localparam int VAL_W      = 32;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [WIN_W-1:0]        win_t;

	// requests from the control fsm to the value store
	typedef struct packed {
		logic   scan_go;
		cnt_t   scan_len;
		logic   wr_en;
		idx_t   wr_addr;
		value_t wr_data;
	} store_cmd_t;

	// outcome of a min scan, held stable until the next scan
	typedef struct packed {
		logic   done;
		idx_t   min_idx;
		value_t min_val;
		value_t tail_val;
	} store_res_t;

	// window of zero acts as one, above the store depth it saturates
	function automatic cnt_t eff_window(input win_t w);
		cnt_t r;
		if (w == '0) begin
			r = cnt_t'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = cnt_t'(MAX_WINDOW);
		end else begin
			r = cnt_t'(w);
		end
		return r;
	endfunction

endpackage

// ===== hdl/kss_store.sv =====
// ============================================================================
// kss_store
// value memory with a one-entry-per-cycle minimum scan
// ============================================================================
module kss_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kss_pkg::store_cmd_t    cmd,
	output kss_pkg::store_res_t    res
);

	kss_pkg::value_t mem [kss_pkg::MAX_WINDOW];

	logic            scanning_q;
	kss_pkg::cnt_t   rd_ptr_q;
	kss_pkg::cnt_t   len_q;
	logic            rd_end;

	logic            rd_vld_s1;
	logic            rd_end_s1;
	kss_pkg::idx_t   rd_idx_s1;
	kss_pkg::value_t rd_data_s1;

	logic            done_q;
	kss_pkg::value_t best_val_q;
	kss_pkg::idx_t   best_idx_q;
	kss_pkg::value_t tail_val_q;

	assign rd_end = (rd_ptr_q == len_q - kss_pkg::cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q <= 1'b0;
			rd_ptr_q   <= '0;
			len_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_end_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.scan_go) begin
				scanning_q <= 1'b1;
				rd_ptr_q   <= '0;
				len_q      <= cmd.scan_len;
			end else if (scanning_q) begin
				rd_ptr_q <= rd_ptr_q + kss_pkg::cnt_t'(1);
				if (rd_end) begin
					scanning_q <= 1'b0;
				end
			end
			rd_vld_s1 <= scanning_q;
			rd_end_s1 <= scanning_q && rd_end;
			done_q    <= rd_vld_s1 && rd_end_s1;
		end
	end

	// memory port and scan datapath
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		rd_data_s1 <= mem[rd_ptr_q[kss_pkg::IDX_W-1:0]];
		rd_idx_s1  <= rd_ptr_q[kss_pkg::IDX_W-1:0];
		if (rd_vld_s1) begin
			if (rd_idx_s1 == '0 || rd_data_s1 < best_val_q) begin
				best_val_q <= rd_data_s1;
				best_idx_q <= rd_idx_s1;
			end
			if (rd_end_s1) begin
				tail_val_q <= rd_data_s1;
			end
		end
	end

	assign res.done     = done_q;
	assign res.min_idx  = best_idx_q;
	assign res.min_val  = best_val_q;
	assign res.tail_val = tail_val_q;

endmodule

// ===== hdl/k_sorted_stream_sorter.sv =====
// ============================================================================
// k_sorted_stream_sorter
// sorts a nearly sorted stream through a small min store
// ============================================================================
//
// channel  | handshake              | payload
// ---------+------------------------+---------------------------
// input    | in_valid / in_stall    | value (s32), last
// output   | out_valid / out_stall  | value_out (s32), last_of_run
// config   | cfg_valid / cfg_ready  | window (5 bits)
//
// an item that only fills the store is written straight in; an item that releases
// a value waits for the one-entry-per-cycle min scan over the value memory
// and then for the emit. a drain after a last mark runs a scan and an emit
// per drained value.
// reset clears the fill count, the fsm and the output valid flag; window is 4.
// the output register lets a new item in while a result waits; a stalled
// output holds the fsm in its emit state until the register frees up.
//
module k_sorted_stream_sorter (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  kss_pkg::value_t       value,
	input  logic                  last,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output kss_pkg::value_t       value_out,
	output logic                  last_of_run,
	// config channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  kss_pkg::win_t         window
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q;
	kss_pkg::cnt_t       held_count_q;
	kss_pkg::win_t       window_q;
	kss_pkg::value_t     value_q;
	logic                last_q;
	logic                drain_q;     // current scan belongs to the drain
	logic                out_valid_q;
	kss_pkg::value_t     value_out_q;
	logic                last_of_run_q;

	kss_pkg::cnt_t       eff_win;
	logic                release_min;
	logic                in_accept;
	logic                out_free;
	logic                emit_fire;
	kss_pkg::store_cmd_t cmd;
	kss_pkg::store_res_t res;

	kss_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	assign eff_win     = kss_pkg::eff_window(window_q);
	assign release_min = (held_count_q >= eff_win) && (held_count_q != '0);
	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign emit_fire   = (state_q == ST_EMIT) && out_free;
	assign cfg_ready   = 1'b1;

	// store requests; a write never lands on an entry under scan because
	// the scan starting at the same edge reads its first entry in the following cycle
	always_comb begin
		cmd = '0;
		if (in_accept) begin
			if (release_min) begin
				// window reached: find the min, the new value replaces it
				cmd.scan_go  = 1'b1;
				cmd.scan_len = held_count_q;
			end else begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = held_count_q[kss_pkg::IDX_W-1:0];
				cmd.wr_data = value;
				if (last) begin
					cmd.scan_go  = 1'b1;
					cmd.scan_len = held_count_q + kss_pkg::cnt_t'(1);
				end
			end
		end else if (emit_fire) begin
			cmd.wr_en   = 1'b1;
			cmd.wr_addr = res.min_idx;
			if (!drain_q) begin
				cmd.wr_data = value_q;
				if (last_q) begin
					cmd.scan_go  = 1'b1;
					cmd.scan_len = held_count_q;
				end
			end else begin
				// drain: tail entry fills the hole left by the min
				cmd.wr_data = res.tail_val;
				if (held_count_q > kss_pkg::cnt_t'(1)) begin
					cmd.scan_go  = 1'b1;
					cmd.scan_len = held_count_q - kss_pkg::cnt_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_count_q <= '0;
			window_q     <= kss_pkg::win_t'(4);
			drain_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= window;
			end

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (release_min) begin
							drain_q <= 1'b0;
							state_q <= ST_SCAN;
						end else begin
							held_count_q <= held_count_q + kss_pkg::cnt_t'(1);
							if (last) begin
								drain_q <= 1'b1;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (res.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (!drain_q) begin
							if (last_q) begin
								drain_q <= 1'b1;
								state_q <= ST_SCAN;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							held_count_q <= held_count_q - kss_pkg::cnt_t'(1);
							if (held_count_q > kss_pkg::cnt_t'(1)) begin
								state_q <= ST_SCAN;
							end else begin
								drain_q <= 1'b0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_q <= value;
			last_q  <= last;
		end
		if (emit_fire) begin
			value_out_q   <= res.min_val;
			last_of_run_q <= drain_q && (held_count_q == kss_pkg::cnt_t'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = value_out_q;
	assign last_of_run = last_of_run_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= kss_pkg::cnt_t'(kss_pkg::MAX_WINDOW))
		else $error("fill count above store depth");

	a_run_end_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && drain_q && held_count_q == kss_pkg::cnt_t'(1))
		|=> (held_count_q == '0 && state_q == ST_IDLE))
		else $error("store not empty after run end");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == ST_SCAN))
		else $error("scan result outside scan state");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (held_count_q != '0))
		else $error("scan over empty store");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// self-checking bench for the k-sorted stream sorter
// ============================================================================
// a directed table walks the reset window, the value extremes, short runs,
// equal values and the window clamps, then random phases send nearly sorted
// runs, noise and unterminated runs under several window settings. every
// accepted input transaction goes through an in-bench min store that
// predicts the sorted output, and every output transaction is checked
// against the oldest prediction.
// ============================================================================
module tb_top;

	localparam int RST_CYCLES   = 7;
	localparam int RANDOM_ITEMS = 350;
	// margin after the last result so that any tail work in the dut has finished
	localparam int SETTLE       = 48;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int MAX_PRINT    = 200;
	localparam int PLAN_ROWS    = 22;

	// one output transaction as the checker sees it
	typedef struct packed {
		kss_pkg::value_t val;
		logic            mark;
	} sorted_t;

	typedef enum logic {ROW_ITEM, ROW_WIN} row_kind_t;

	// one row of the directed table; a window row carries the setting in val
	typedef struct packed {
		row_kind_t       kind;
		kss_pkg::value_t val;
		logic            lst;
		logic            typed;  // expectation written out below instead of predicted
		logic            n_exp;  // typed rows cause either no result or one
		sorted_t         want;
	} row_t;

	// directed table, window starts at its reset value of 4
	row_t plan [PLAN_ROWS] = '{
		// fill the store with the value extremes, nothing comes out yet
		'{ROW_ITEM, 32'sh7fffffff, 1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sh80000000, 1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sh00000000, 1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'shffffffff, 1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		// store full, the most negative value leaves first
		'{ROW_ITEM, 32'sd5,        1'b0, 1'b1, 1'b1, '{32'sh80000000, 1'b0}},
		// last mark with a full store: release, insert, full drain
		'{ROW_ITEM, 32'sd3,        1'b1, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		// single item run comes straight back with the run-end mark
		'{ROW_ITEM, 32'sd100,      1'b1, 1'b1, 1'b1, '{32'sd100, 1'b1}},
		// short run below the window drains what is held
		'{ROW_ITEM, -32'sd7,       1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, -32'sd9,       1'b1, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		// equal values
		'{ROW_ITEM, 32'sd42,       1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd42,       1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd42,       1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd42,       1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd42,       1'b1, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		// alternating bit patterns
		'{ROW_ITEM, 32'sh55555555, 1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'shaaaaaaaa, 1'b1, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		// window of zero behaves as one
		'{ROW_WIN,  32'sd0,        1'b0, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd10,       1'b0, 1'b1, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd20,       1'b0, 1'b1, 1'b1, '{32'sd10, 1'b0}},
		'{ROW_ITEM, 32'sd15,       1'b1, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		// window above the store depth saturates
		'{ROW_WIN,  32'sd31,       1'b0, 1'b0, 1'b0, '{32'sh0, 1'b0}},
		'{ROW_ITEM, 32'sd1,        1'b1, 1'b1, 1'b1, '{32'sd1, 1'b1}}
	};

	// dut side signals, all inputs known from time zero
	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	kss_pkg::value_t value     = '0;
	logic            last      = 1'b0;
	logic            out_stall = 1'b0;
	logic            cfg_valid = 1'b0;
	kss_pkg::win_t   window    = '0;
	logic            in_stall;
	logic            out_valid;
	kss_pkg::value_t value_out;
	logic            last_of_run;
	logic            cfg_ready;

	// predicted store contents and settings
	kss_pkg::value_t held [kss_pkg::MAX_WINDOW];
	int              held_n      = 0;
	kss_pkg::win_t   win_setting = kss_pkg::win_t'(4);
	sorted_t fresh[$];           // results of the latest accepted transaction
	sorted_t pending_sorted[$];  // results still owed by the dut

	int   errors     = 0;
	int   cycles     = 0;
	int   items_sent = 0;
	logic send_calm  = 1'b0;
	logic hold_go    = 1'b0;
	logic hold_off   = 1'b0;
	int   rx_gap_left  = 0;
	int   rx_calm_left = 0;
	logic rx_calm      = 1'b0;

	k_sorted_stream_sorter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.last_of_run (last_of_run),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.window      (window)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// window as the store uses it: zero counts as one, capped at the depth
	function automatic int window_limit();
		int w;
		w = int'(win_setting);
		if (w < 1) w = 1;
		if (w > kss_pkg::MAX_WINDOW) w = kss_pkg::MAX_WINDOW;
		return w;
	endfunction

	// remove the smallest held value, order among equals does not matter
	function automatic kss_pkg::value_t pop_smallest();
		int              best;
		kss_pkg::value_t v;
		best = 0;
		for (int i = 1; i < held_n; i++) begin
			if (held[i] < held[best]) best = i;
		end
		v = held[best];
		held_n--;
		held[best] = held[held_n];
		return v;
	endfunction

	// queue one unmarked result of the current transaction
	function automatic void add_fresh(input kss_pkg::value_t v);
		sorted_t r;
		r.val  = v;
		r.mark = 1'b0;
		fresh  = {fresh, r};
	endfunction

	// one accepted input transaction: release if the window is reached,
	// insert, and on a last mark drain everything in ascending order
	function automatic void sort_step(input kss_pkg::value_t v, input logic lst);
		fresh.delete();
		if (held_n >= window_limit() && held_n > 0) begin
			add_fresh(pop_smallest());
		end
		if (held_n < kss_pkg::MAX_WINDOW) begin
			held[held_n] = v;
			held_n++;
		end
		if (lst) begin
			while (held_n > 0) add_fresh(pop_smallest());
			fresh[fresh.size() - 1].mark = 1'b1;
		end
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) return $urandom_range(1, 3);
		if (pick < 95) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_PRINT) $display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	// offer one input transaction and hold it until accepted
	task automatic send_item(input kss_pkg::value_t v, input logic lst, input logic typed,
			input logic n_exp, input sorted_t want);
		int gap;
		in_valid <= 1'b1;
		value    <= v;
		last     <= lst;
		do @(posedge clk); while (in_stall);
		sort_step(v, lst);
		if (typed) begin
			if (n_exp) pending_sorted = {pending_sorted, want};
		end else begin
			foreach (fresh[i]) pending_sorted = {pending_sorted, fresh[i]};
		end
		items_sent++;
		// flip between stretches with and without sender gaps
		if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
		gap = (!send_calm && $urandom_range(0, 99) < 35) ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending until every predicted result has been seen
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_sorted.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(input kss_pkg::win_t w);
		wait_drained();
		cfg_valid <= 1'b1;
		window    <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		win_setting = w;
	endtask

	// one run: either nearly sorted (ascending with short reversed stretches,
	// so no value is further from its place than the window) or noise
	task automatic send_sequence(input logic close, input logic long_run);
		kss_pkg::value_t seq[$];
		kss_pkg::value_t base;
		kss_pkg::value_t t;
		int     len;
		int     wl;
		int     s;
		int     c;
		logic   noise;
		logic   lst;
		wl    = window_limit();
		noise = !long_run && ($urandom_range(0, 3) == 0);
		if (long_run) len = 30;
		else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 48);
		else len = $urandom_range(1, 2 * wl + 3);
		base = $signed($urandom) >>> 1;
		for (int i = 0; i < len; i++) begin
			if (noise) begin
				seq = {seq, kss_pkg::value_t'($urandom)};
			end else begin
				if ($urandom_range(0, 3) != 0) base = base + $urandom_range(1, 5000);
				seq = {seq, base};
			end
		end
		if (!noise) begin
			s = 0;
			while (s < len) begin
				c = $urandom_range(1, wl);
				if (s + c > len) c = len - s;
				for (int i = 0; i < c / 2; i++) begin
					t              = seq[s + i];
					seq[s + i]     = seq[s + c - 1 - i];
					seq[s + c - 1 - i] = t;
				end
				s += c;
			end
		end
		foreach (seq[i]) begin
			// noise also throws in stray last marks
			lst = (close && i == len - 1) || (noise && $urandom_range(0, 7) == 0);
			send_item(seq[i], lst, 1'b0, 1'b0, '0);
		end
	endtask

	// long receiver hold-off so the store fills and the input stalls
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// output side: check each accepted transaction, then pick the next stall
	always @(posedge clk) begin : result_side
		sorted_t want;
		if (out_valid && !out_stall) begin
			if (pending_sorted.size() == 0) begin
				report($sformatf("unexpected transaction value_out %0d last_of_run %0b",
					value_out, last_of_run));
			end else begin
				want = pending_sorted.pop_front();
				if (value_out !== want.val) begin
					report($sformatf("value_out got %0d expected %0d", value_out, want.val));
				end
				if (last_of_run !== want.mark) begin
					report($sformatf("last_of_run got %0b expected %0b",
						last_of_run, want.mark));
				end
			end
		end
		// stretches with no gap stalls are mixed in among stalled ones
		if (rx_calm_left == 0) begin
			rx_calm      = ($urandom_range(0, 3) == 0);
			rx_calm_left = $urandom_range(50, 300);
		end else begin
			rx_calm_left--;
		end
		if (rx_gap_left > 0) begin
			rx_gap_left--;
		end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
			rx_gap_left = gap_len();
		end
		out_stall <= hold_off || (rx_gap_left > 0);
	end

	initial begin : stimulus
		int            phase;
		int            n_seq;
		int            random_start;
		logic          close;
		kss_pkg::win_t w;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WIN) begin
				write_window(kss_pkg::win_t'(plan[r].val));
			end else begin
				send_item(plan[r].val, plan[r].lst, plan[r].typed, plan[r].n_exp,
					plan[r].want);
			end
		end

		// random phases; a phase may stop mid-run, so the next window
		// setting can land on a partly filled store
		random_start = items_sent;
		phase        = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			case (phase)
				0: w = kss_pkg::win_t'(16);
				1: w = kss_pkg::win_t'(31);
				2: w = kss_pkg::win_t'(1);
				3: w = kss_pkg::win_t'(0);
				4: w = kss_pkg::win_t'(2);
				default: w = kss_pkg::win_t'($urandom_range(0, 31));
			endcase
			write_window(w);
			if (phase == 0) hold_go = 1'b1;
			n_seq = $urandom_range(1, 3);
			for (int s = 0; s < n_seq; s++) begin
				close = (s < n_seq - 1) || ($urandom_range(0, 3) != 0);
				send_sequence(close, phase == 0 && s == 0);
			end
			phase++;
		end

		wait_drained();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
